// ----- design/slice_bounds_normalize_and_length_top_defines.svh -----
// Assertion macros for the slice bounds normalizer top level.
// Depends on nothing; included by files that carry assertions.
`ifndef SLICE_BOUNDS_NORMALIZE_AND_LENGTH_TOP_DEFINES_SVH
`define SLICE_BOUNDS_NORMALIZE_AND_LENGTH_TOP_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define SBN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Property that must hold on every clock edge, reset included.
`define SBN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

// ----- design/sbn_pkg.sv -----
// Package for the slice bounds normalizer: widths and constants.
// Depends on nothing.
package sbn_pkg;
    localparam int DIM_WIDTH_DEF = 32;
    localparam logic signed [63:0] HUGE_POS = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] HUGE_NEG = 64'shC000_0000_0000_0000;
endpackage

// ----- design/sbn_bounds.sv -----
// Bounds stage of the slice normalizer: unbounded markers, wrap and clamp.
// Depends on sbn_pkg.
module sbn_bounds #(
    parameter int DW = sbn_pkg::DIM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DW-1:0]        i_size,
    input  logic signed [63:0]   i_start,
    input  logic signed [63:0]   i_end,
    input  logic signed [63:0]   i_step,
    output logic                 o_valid,
    output logic signed [DW:0]   o_first,
    output logic signed [DW:0]   o_stop,
    output logic [63:0]          o_mag,
    output logic                 o_rev,
    output logic                 o_bad
);
    import sbn_pkg::*;

    logic                r_valid;
    logic signed [DW:0]  r_first;
    logic signed [DW:0]  r_stop;
    logic [63:0]         r_mag;
    logic                r_rev;
    logic                r_bad;
    logic signed [DW:0]  n_first;
    logic signed [DW:0]  n_stop;
    logic signed [65:0]  v_size;
    logic signed [65:0]  v_s;
    logic signed [65:0]  v_e;

    always_comb begin
        v_size = 66'(signed'({1'b0, i_size}));
        v_s = 66'(i_start);
        v_e = 66'(i_end);
        if (!i_step[63]) begin
            if (i_end >= HUGE_POS) v_e = v_size;
            if (i_start <= HUGE_NEG) v_s = '0;
            if (v_s < 0) v_s = v_s + v_size;
            if (v_e < 0) v_e = v_e + v_size;
            if (v_s < 0) v_s = '0;
            if (v_s > v_size) v_s = v_size;
            if (v_e < 0) v_e = '0;
            if (v_e > v_size) v_e = v_size;
        end else begin
            if (i_start >= HUGE_POS) v_s = v_size - 66'sd1;
            if (i_end <= HUGE_NEG) v_e = -66'sd1;
            if (v_s < 0 && v_s >= -v_size) v_s = v_s + v_size;
            if (v_e < -66'sd1 && v_e >= -v_size) v_e = v_e + v_size;
            if (v_s < -66'sd1) v_s = -66'sd1;
            if (v_s > v_size - 66'sd1) v_s = v_size - 66'sd1;
            if (v_e < -66'sd1) v_e = -66'sd1;
            if (v_e > v_size - 66'sd1) v_e = v_size - 66'sd1;
        end
        n_first = v_s[DW:0];
        n_stop  = v_e[DW:0];
        if (i_step == '0) begin
            n_first = '0;
            n_stop  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_first <= n_first;
            r_stop  <= n_stop;
            r_mag   <= i_step[63] ? 64'(-i_step) : i_step;
            r_rev   <= i_step[63];
            r_bad   <= (i_step == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_first = r_first;
    assign o_stop  = r_stop;
    assign o_mag   = r_mag;
    assign o_rev   = r_rev;
    assign o_bad   = r_bad;
endmodule

// ----- design/sbn_divider.sv -----
// Pipelined restoring divider: count = (span - 1) / mag + 1, one bit a stage.
// Depends on sbn_pkg.
module sbn_divider #(
    parameter int DW = sbn_pkg::DIM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW:0]   i_first,
    input  logic signed [DW:0]   i_stop,
    input  logic [63:0]          i_mag,
    input  logic                 i_rev,
    input  logic                 i_bad,
    output logic                 o_valid,
    output logic signed [DW:0]   o_first,
    output logic signed [DW:0]   o_stop,
    output logic [DW-1:0]        o_count,
    output logic                 o_bad
);
    import sbn_pkg::*;

    logic                r_valid [DW+1];
    logic signed [DW:0]  r_first [DW+1];
    logic signed [DW:0]  r_stop  [DW+1];
    logic [63:0]         r_mag   [DW+1];
    logic                r_bad   [DW+1];
    logic                r_nz    [DW+1];
    logic [DW-1:0]       r_rem   [DW+1];
    logic [DW-1:0]       r_quo   [DW+1];
    logic [DW-1:0]       r_num   [DW+1];
    logic signed [DW+1:0] v_span;
    logic                n_nz;

    always_comb begin
        if (i_rev) v_span = (DW+2)'(i_first) - (DW+2)'(i_stop);
        else       v_span = (DW+2)'(i_stop) - (DW+2)'(i_first);
        n_nz = !i_bad && (v_span > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) r_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= DW; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first[0] <= i_first;
            r_stop[0]  <= i_stop;
            r_mag[0]   <= i_mag;
            r_bad[0]   <= i_bad;
            r_nz[0]    <= n_nz;
            r_rem[0]   <= '0;
            r_quo[0]   <= '0;
            r_num[0]   <= n_nz ? DW'(v_span - 1) : '0;
            for (int k = 1; k <= DW; k++) begin
                logic [DW:0] t;
                t = {r_rem[k-1], r_num[k-1][DW-1]};
                r_first[k] <= r_first[k-1];
                r_stop[k]  <= r_stop[k-1];
                r_mag[k]   <= r_mag[k-1];
                r_bad[k]   <= r_bad[k-1];
                r_nz[k]    <= r_nz[k-1];
                r_num[k]   <= r_num[k-1] << 1;
                if (64'(t) >= r_mag[k-1]) begin
                    r_rem[k] <= DW'(64'(t) - r_mag[k-1]);
                    r_quo[k] <= {r_quo[k-1][DW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= t[DW-1:0];
                    r_quo[k] <= {r_quo[k-1][DW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[DW];
    assign o_first = r_first[DW];
    assign o_stop  = r_stop[DW];
    assign o_count = r_nz[DW] ? r_quo[DW] + DW'(1) : '0;
    assign o_bad   = r_bad[DW];
endmodule

// ----- design/slice_bounds_normalize_and_length_top.sv -----
// Slice bounds normalizer for one tensor axis.
// Item in: axis size with signed start, end and step; item out: normalized
// first and stop indices, the element count and a zero-step flag.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. One item is accepted every cycle while the output side
// does not stall. The pipeline has one bounds stage, one span stage, one
// divider stage per quotient bit, and the output register. The element
// count is a ceiling division by the step magnitude done by the
// bit-per-stage divider.
// When the receiver stalls while the output register holds an item that is
// not taken, the whole pipeline holds; only then does the input side see stall.
// Reset clears all valid bits; in-flight items are dropped.
// Results are zero with the flag set for a step of zero.
// The pipeline has no state beyond the items in flight.
module slice_bounds_normalize_and_length_top #(
    parameter int DIM_WIDTH = sbn_pkg::DIM_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [DIM_WIDTH-1:0]     i_dim_size,
    input  logic signed [63:0]       i_start_index,
    input  logic signed [63:0]       i_end_index,
    input  logic signed [63:0]       i_step_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DIM_WIDTH:0] o_first_index,
    output logic signed [DIM_WIDTH:0] o_stop_index,
    output logic [DIM_WIDTH-1:0]     o_element_count,
    output logic                     o_bad_step
);
    import sbn_pkg::*;
    `include "slice_bounds_normalize_and_length_top_defines.svh"

    logic                     w_en;
    logic                     b_valid, b_rev, b_bad;
    logic signed [DIM_WIDTH:0] b_first, b_stop;
    logic [63:0]              b_mag;
    logic                     d_valid, d_bad;
    logic signed [DIM_WIDTH:0] d_first, d_stop;
    logic [DIM_WIDTH-1:0]     d_count;
    logic                     r_valid, r_bad;
    logic signed [DIM_WIDTH:0] r_first, r_stop;
    logic [DIM_WIDTH-1:0]     r_count;

    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    sbn_bounds #(.DW(DIM_WIDTH)) u_bounds (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid,
        .i_size(i_dim_size), .i_start(i_start_index), .i_end(i_end_index),
        .i_step(i_step_value), .o_valid(b_valid), .o_first(b_first),
        .o_stop(b_stop), .o_mag(b_mag), .o_rev(b_rev), .o_bad(b_bad)
    );

    sbn_divider #(.DW(DIM_WIDTH)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(b_valid),
        .i_first(b_first), .i_stop(b_stop), .i_mag(b_mag), .i_rev(b_rev),
        .i_bad(b_bad), .o_valid(d_valid), .o_first(d_first), .o_stop(d_stop),
        .o_count(d_count), .o_bad(d_bad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= d_valid;
        end
        if (w_en) begin
            r_first <= d_first;
            r_stop  <= d_stop;
            r_count <= d_count;
            r_bad   <= d_bad;
        end
    end

    assign o_valid         = r_valid;
    assign o_first_index   = r_first;
    assign o_stop_index    = r_stop;
    assign o_element_count = r_count;
    assign o_bad_step      = r_bad;

    `SBN_ASSERT(a_bad_zero, (o_valid && o_bad_step) |-> (o_element_count == '0 && o_first_index == '0 && o_stop_index == '0), "bad step with nonzero outputs")
    `SBN_ASSERT(a_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_element_count)), "stalled item changed")
    `SBN_ASSERT(a_stall_src, o_stall |-> (o_valid && i_stall), "input stalled without cause")
    `SBN_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

// ----- tb/tb_slice_bounds_normalize_and_length_top.sv -----
// Self-checking testbench for the slice bounds normalizer top level.
// Drives axis requests with random idling and stalls and checks every result
// against a table or a built-in slice-bounds predictor; depends on sbn_pkg.
`timescale 1ns / 100ps

module tb_slice_bounds_normalize_and_length_top;
    import sbn_pkg::*;

    localparam int DW = DIM_WIDTH_DEF;
    localparam int LATENCY = DW + 3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 930;

    typedef struct packed {
        logic [DW-1:0] dim;
        logic signed [63:0] start;
        logic signed [63:0] stop;
        logic signed [63:0] step;
    } request_t;

    typedef struct packed {
        logic signed [DW:0] first;
        logic signed [DW:0] last;
        logic [DW-1:0] count;
        logic bad;
    } bounds_t;

    typedef struct packed {
        request_t req;
        logic has_exp;
        bounds_t exp;
    } table_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [DW-1:0] i_dim_size = '0;
    logic signed [63:0] i_start_index = '0;
    logic signed [63:0] i_end_index = '0;
    logic signed [63:0] i_step_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [DW:0] o_first_index;
    logic signed [DW:0] o_stop_index;
    logic [DW-1:0] o_element_count;
    logic o_bad_step;

    bounds_t expected_bounds[$];
    int error_count = 0;
    int checked_count = 0;
    int sent_count = 0;
    int bad_step_seen = 0;
    int idle_in_pct = 0;
    int stall_out_pct = 0;
    int quiet_cycles = 0;
    table_row_t directed[$];

    slice_bounds_normalize_and_length_top #(.DIM_WIDTH(DW)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_dim_size(i_dim_size), .i_start_index(i_start_index),
        .i_end_index(i_end_index), .i_step_value(i_step_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_first_index(o_first_index),
        .o_stop_index(o_stop_index), .o_element_count(o_element_count),
        .o_bad_step(o_bad_step)
    );

    always #6 i_clk = ~i_clk;

    function automatic bounds_t normalize_bounds(request_t r);
        bounds_t b;
        logic signed [65:0] size;
        logic signed [65:0] s;
        logic signed [65:0] e;
        logic [65:0] mag;
        logic [65:0] span;
        b = '0;
        size = $signed({34'd0, r.dim});
        s = r.start;
        e = r.stop;
        if (r.step == 0) begin
            b.bad = 1'b1;
            return b;
        end
        if (r.step > 0) begin
            mag = r.step;
            if (e >= HUGE_POS) e = size;
            if (s <= HUGE_NEG) s = 0;
            if (s < 0) s = s + size;
            if (e < 0) e = e + size;
            s = (s < 0) ? 0 : (s > size) ? size : s;
            e = (e < 0) ? 0 : (e > size) ? size : e;
            if (e > s) begin
                span = e - s;
                b.count = (span - 1) / mag + 1;
            end
        end else begin
            mag = -$signed({{2{r.step[63]}}, r.step});
            if (s >= HUGE_POS) s = size - 1;
            if (e <= HUGE_NEG) e = -1;
            if (s < 0 && s >= -size) s = s + size;
            if (e < -1 && e >= -size) e = e + size;
            s = (s < -1) ? -1 : (s > size - 1) ? size - 1 : s;
            e = (e < -1) ? -1 : (e > size - 1) ? size - 1 : e;
            if (s > e) begin
                span = s - e;
                b.count = (span - 1) / mag + 1;
            end
        end
        b.first = s[DW:0];
        b.last = e[DW:0];
        return b;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", field, got, want,
                 checked_count);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        bounds_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bounds.size() == 0) begin
                report_mismatch("unexpected item", 64'(o_element_count), 0);
            end else begin
                want = expected_bounds.pop_front();
                if (o_first_index !== want.first)
                    report_mismatch("first_index", 64'(o_first_index), 64'(want.first));
                if (o_stop_index !== want.last)
                    report_mismatch("stop_index", 64'(o_stop_index), 64'(want.last));
                if (o_element_count !== want.count)
                    report_mismatch("element_count", 64'(o_element_count),
                                    64'(want.count));
                if (o_bad_step !== want.bad)
                    report_mismatch("bad_step", 64'(o_bad_step), 64'(want.bad));
                if (want.bad) bad_step_seen++;
            end
            checked_count++;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_out_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results pending",
                         expected_bounds.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic signed [63:0] pick_index(logic [DW-1:0] dim);
        logic signed [63:0] v;
        case ($urandom_range(7))
            0: v = {$urandom, $urandom};
            1: v = HUGE_POS + $urandom_range(3);
            2: v = HUGE_NEG - $urandom_range(3);
            3: v = -64'sd1;
            4: v = -$signed({32'd0, dim}) + $signed(64'($urandom_range(4))) - 2;
            5: v = $signed({32'd0, dim}) + $signed(64'($urandom_range(4))) - 2;
            default: v = $signed(64'($urandom_range(2 * int'(dim[15:0]) + 2)))
                         - $signed(64'(dim[15:0])) - 1;
        endcase
        return v;
    endfunction

    function automatic request_t random_request();
        request_t r;
        case ($urandom_range(3))
            0: r.dim = $urandom;
            1: r.dim = '1 - $urandom_range(2);
            2: r.dim = $urandom_range(2);
            default: r.dim = $urandom_range(300);
        endcase
        r.start = pick_index(r.dim);
        r.stop = pick_index(r.dim);
        case ($urandom_range(9))
            0: r.step = {$urandom, $urandom};
            1: r.step = 64'sh8000_0000_0000_0000 + $urandom_range(1);
            2: r.step = 64'sh7FFF_FFFF_FFFF_FFFF;
            3: r.step = 0;
            4, 5: r.step = -$signed(64'($urandom_range(5, 1)));
            default: r.step = $signed(64'($urandom_range(5, 1)));
        endcase
        return r;
    endfunction

    task automatic send_request(request_t r);
        while ($urandom_range(99) < idle_in_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_dim_size <= r.dim;
        i_start_index <= r.start;
        i_end_index <= r.stop;
        i_step_value <= r.step;
        expected_bounds.insert(expected_bounds.size(), normalize_bounds(r));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic add_row(logic [DW-1:0] d, logic signed [63:0] s, logic signed [63:0] e,
                           logic signed [63:0] st, logic known, bounds_t b);
        table_row_t row;
        row.req = '{dim: d, start: s, stop: e, step: st};
        row.has_exp = known;
        row.exp = b;
        directed.insert(directed.size(), row);
    endtask

    initial begin
        bounds_t z;
        request_t r;
        z = '0;
        add_row(10, 3, 7, 0, 1, '{first: 0, last: 0, count: 0, bad: 1});
        add_row(10, 0, 10, 1, 1, '{first: 0, last: 10, count: 10, bad: 0});
        add_row(10, HUGE_NEG, HUGE_POS, 1, 1, '{first: 0, last: 10, count: 10, bad: 0});
        add_row(10, HUGE_POS, HUGE_NEG, -1, 1, '{first: 9, last: -1, count: 10, bad: 0});
        add_row(10, -1, -1, -1, 1, '{first: 9, last: -1, count: 10, bad: 0});
        add_row(10, -20, -30, -1, 1, '{first: -1, last: -1, count: 0, bad: 0});
        add_row(0, 0, 5, 1, 1, '{first: 0, last: 0, count: 0, bad: 0});
        add_row(0, 5, 0, -1, 1, '{first: -1, last: -1, count: 0, bad: 0});
        add_row('1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                64'sh7FFF_FFFF_FFFF_FFFF, 0, z);
        add_row('1, 64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
                64'sh8000_0000_0000_0000, 1,
                '{first: 33'h0_FFFF_FFFE, last: -1, count: 1, bad: 0});
        add_row('1, 0, HUGE_POS, 1, 1, '{first: 0, last: 33'h0_FFFF_FFFF,
                count: 32'hFFFF_FFFF, bad: 0});
        add_row(10, -3, 100, 2, 0, z);
        add_row(10, 8, 2, -3, 0, z);
        add_row(10, -10, -11, -1, 0, z);
        add_row(10, -11, 5, 1, 0, z);
        add_row(7, 1, 7, 3, 0, z);
        add_row(1, 0, 1, 1, 0, z);
        add_row(10, HUGE_POS - 1, HUGE_NEG + 1, -1, 0, z);
        add_row(10, 5, 5, 1, 0, z);
        add_row(10, 5, 5, -1, 0, z);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_in_pct = 33;
        stall_out_pct = 68;
        foreach (directed[k]) begin
            send_request(directed[k].req);
            if (directed[k].has_exp)
                expected_bounds[expected_bounds.size() - 1] = directed[k].exp;
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                idle_in_pct = 68;
                stall_out_pct = 33;
            end
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (expected_bounds.size() != 0) @(negedge i_clk);
            end
            if (n == 2 * N_RANDOM / 3) begin
                idle_in_pct = 0;
                stall_out_pct = 0;
            end
            r = random_request();
            send_request(r);
        end
        i_valid <= 1'b0;
        while (expected_bounds.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("Sent %0d requests and checked %0d results, %0d with a zero step,",
                 sent_count, checked_count, bad_step_seen);
        $display("covering unbounded markers, wrap, clamp, empty axes and extreme steps.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
